>>> sv/xcorr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the full cross-correlation block.
// No dependencies.
package xcorr_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int PROD_W       = 32;
    localparam int CORR_W       = 37;
    localparam int TIDX_W       = 5;
    localparam int TCNT_W       = 6;
    localparam int MAX_TAPS_DEF = 32;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [TCNT_W-1:0] TAP_COUNT_RESET = 6'd32;

    // queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_TAP_COUNT = 1'b0;

    typedef struct packed {
        logic                       op;
        logic [TIDX_W-1:0]          tap_index;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } xcorr_item_t;

endpackage

>>> sv/xcorr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xcorr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/xcorr_front.sv
`timescale 1ns / 1ps
// Input side: takes item transfers and holds them in a short queue for the back end.
// Depends on xcorr_pkg.
module xcorr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            op,
    input  logic [xcorr_pkg::TIDX_W-1:0]    tap_index,
    input  logic signed [xcorr_pkg::SAMPLE_W-1:0] sample,
    input  logic                            last,
    output logic                            q_valid,
    output xcorr_pkg::xcorr_item_t          q_item,
    input  logic                            q_pop
);
    import xcorr_pkg::*;

    xcorr_item_t       entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wp_reg;
    logic [QP_W-1:0]   wp_next;
    logic [QP_W-1:0]   rp_reg;
    logic [QP_W-1:0]   rp_next;
    logic [QC_W-1:0]   count_reg;
    logic [QC_W-1:0]   count_next;
    logic              push;
    logic              pop;
    xcorr_item_t       in_item;

    assign item_stall = (count_reg == QC_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = entry_reg[rp_reg];

    always_comb
    begin
        in_item.op        = op;
        in_item.tap_index = tap_index;
        in_item.sample    = sample;
        in_item.last      = (op == OP_SIGNAL) ? last : 1'b0;
    end

    always_comb
    begin
        wp_next    = push ? wp_reg + QP_W'(1) : wp_reg;
        rp_next    = pop ? rp_reg + QP_W'(1) : rp_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/xcorr_mac.sv
`timescale 1ns / 1ps
// Back end: reference and history stores, shared multiply-accumulate, tail flush, output register.
// Depends on xcorr_pkg and xcorr_ram.
module xcorr_mac #(
    parameter int MAX_TAPS = xcorr_pkg::MAX_TAPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [xcorr_pkg::TCNT_W-1:0]    tap_count,
    input  logic                            q_valid,
    input  xcorr_pkg::xcorr_item_t          q_item,
    output logic                            q_pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [xcorr_pkg::CORR_W-1:0] corr_value,
    output logic                            last_out
);
    import xcorr_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int NW = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [AW-1:0]              hp_reg, hp_next;
    logic [NW-1:0]              k_reg, k_next;
    logic [NW-1:0]              n_reg, n_next;
    logic [NW-1:0]              tail_reg, tail_next;
    logic                       last_reg, last_next;
    logic [MAX_TAPS-1:0]        hvalid_reg, hvalid_next;
    logic                       rd_v_reg, rd_v_next;
    logic                       hv_reg, hv_next;
    logic                       prod_v_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CORR_W-1:0]   acc_reg, acc_next;
    logic                       res_v_reg, res_v_next;
    logic signed [CORR_W-1:0]   corr_reg;
    logic                       last_out_reg;

    logic [NW-1:0]              n_act;
    logic                       out_free;
    logic                       emit;
    logic                       ref_we;
    logic [AW-1:0]              ref_waddr;
    logic [AW-1:0]              ref_raddr;
    logic [SAMPLE_W-1:0]        ref_rdata;
    logic                       hist_we;
    logic [SAMPLE_W-1:0]        hist_rdata;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(MAX_TAPS - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        ring_dec = (p == '0) ? AW'(MAX_TAPS - 1) : p - AW'(1);
    endfunction

    always_comb
    begin
        priority if (tap_count == '0)
        begin
            n_act = NW'(1);
        end
        else if (int'(tap_count) > MAX_TAPS)
        begin
            n_act = NW'(MAX_TAPS);
        end
        else
        begin
            n_act = NW'(tap_count);
        end
    end

    assign ref_we    = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_LOAD)
                       && (int'(q_item.tap_index) < MAX_TAPS);
    assign ref_waddr = AW'(q_item.tap_index);
    assign ref_raddr = AW'(n_reg - k_reg - NW'(1));
    assign hist_we   = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_SIGNAL);

    xcorr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (q_item.sample),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    xcorr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (q_item.sample),
        .raddr (hp_reg),
        .rdata (hist_rdata)
    );

    assign out_free = !res_v_reg || !result_stall;
    assign emit     = (state_reg == S_DRAIN) && !rd_v_reg && !prod_v_reg && out_free;
    assign q_pop    = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        hp_next     = hp_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        tail_next   = tail_reg;
        last_next   = last_reg;
        hvalid_next = hvalid_reg;
        rd_v_next   = 1'b0;
        hv_next     = hvalid_reg[hp_reg];
        acc_next    = prod_v_reg
                      ? acc_reg + {{(CORR_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg}
                      : acc_reg;
        res_v_next  = res_v_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (hist_we)
                begin
                    hvalid_next[wp_reg] = 1'b1;
                    hp_next    = wp_reg;
                    wp_next    = ring_inc(wp_reg);
                    k_next     = '0;
                    n_next     = n_act;
                    last_next  = q_item.last;
                    tail_next  = q_item.last ? n_act - NW'(1) : '0;
                    acc_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                rd_v_next = 1'b1;
                hp_next   = ring_dec(hp_reg);
                k_next    = k_reg + NW'(1);
                if (k_reg == n_reg - NW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (emit)
                begin
                    res_v_next = 1'b1;
                    if (tail_reg != '0)
                    begin
                        // shift a zero into the history
                        hvalid_next[wp_reg] = 1'b0;
                        hp_next    = wp_reg;
                        wp_next    = ring_inc(wp_reg);
                        k_next     = '0;
                        tail_next  = tail_reg - NW'(1);
                        acc_next   = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            hvalid_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mul_a = signed'(ref_rdata);
    assign mul_b = hv_reg ? signed'(hist_rdata) : '0;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        hp_reg   <= hp_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        tail_reg <= tail_next;
        last_reg <= last_next;
        hv_reg   <= hv_next;
        if (emit)
        begin
            corr_reg     <= acc_reg;
            last_out_reg <= last_reg && (tail_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            hvalid_reg <= '0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            hvalid_reg <= hvalid_next;
            rd_v_reg   <= rd_v_next;
            prod_v_reg <= rd_v_reg;
            res_v_reg  <= res_v_next;
        end
    end

    assign result_valid = res_v_reg;
    assign corr_value   = corr_reg;
    assign last_out     = last_out_reg;

endmodule

>>> sv/full_cross_correlation_top.sv
`timescale 1ns / 1ps
// Full cross-correlation top: APB register, input queue and MAC back end.
// Each signal item gives one result; one with last set adds n-1 tail results, fed zeros
// (n = active taps). One load item per cycle while the back end is idle and the queue has room;
// a signal item holds the single MAC, and the next item waits until its last result is emitted.
// Reset: tap_count = 32, sample history reads as zeros, reference store undefined until loaded.
module full_cross_correlation_top #(
    parameter int MAX_TAPS = xcorr_pkg::MAX_TAPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [xcorr_pkg::PADDR_W-1:0]         paddr,
    input  logic [xcorr_pkg::PDATA_W-1:0]         pwdata,
    output logic [xcorr_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  op,
    input  logic [xcorr_pkg::TIDX_W-1:0]          tap_index,
    input  logic signed [xcorr_pkg::SAMPLE_W-1:0] sample,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [xcorr_pkg::CORR_W-1:0]   corr_value,
    output logic                                  last_out
);
    import xcorr_pkg::*;

    logic [TCNT_W-1:0] tap_count_reg;
    logic              cfg_wr;
    logic              q_valid;
    logic              q_pop;
    xcorr_item_t       q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT);
    assign prdata = (paddr[2] == REG_TAP_COUNT)
                    ? {{(PDATA_W - TCNT_W){1'b0}}, tap_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            tap_count_reg <= pwdata[TCNT_W-1:0];
        end
    end

    xcorr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .tap_index  (tap_index),
        .sample     (sample),
        .last       (last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    xcorr_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_count    (tap_count_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .corr_value   (corr_value),
        .last_out     (last_out)
    );

endmodule

>>> sim/xcorr_checker.sv
`timescale 1ns / 1ps
// Checker for the full cross-correlation block: follows register writes and item
// transfers, predicts the correlation values and compares every result transfer.
// Depends on xcorr_pkg.
module xcorr_checker
    import xcorr_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    input  logic                        pready,
    input  logic                        item_valid,
    input  logic                        item_stall,
    input  logic                        op,
    input  logic [TIDX_W-1:0]           tap_index,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        last,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic signed [CORR_W-1:0]    corr_value,
    input  logic                        last_out,
    output int                          mismatch_count,
    output int                          pending_count
);

    typedef struct packed {
        logic signed [CORR_W-1:0] corr;
        logic                     final_flag;
    } corr_result_t;

    corr_result_t               expected_corr_q[$];
    logic signed [SAMPLE_W-1:0] tap_store [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] sample_line [MAX_TAPS];
    logic [TCNT_W-1:0]          tap_count_reg;
    int                         err_cnt;

    function automatic int unsigned taps_in_use(logic [TCNT_W-1:0] tc);
        if (tc == 0)
            return 1;
        if (tc > MAX_TAPS)
            return MAX_TAPS;
        return tc;
    endfunction

    function automatic logic signed [CORR_W-1:0] dot_product(int unsigned n);
        longint acc;
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(tap_store[n-1-k]) * longint'(sample_line[k]);
        return acc[CORR_W-1:0];
    endfunction

    function automatic void shift_line(logic signed [SAMPLE_W-1:0] v);
        for (int k = MAX_TAPS - 1; k > 0; k--)
            sample_line[k] = sample_line[k-1];
        sample_line[0] = v;
    endfunction

    function automatic void clear_line();
        for (int k = 0; k < MAX_TAPS; k++)
            sample_line[k] = '0;
    endfunction

    // one signal sample, plus the zero-fed tail when it closes a sequence
    function automatic void predict_correlation(logic signed [SAMPLE_W-1:0] s, logic is_final);
        int unsigned n;
        corr_result_t r;
        n = taps_in_use(tap_count_reg);
        shift_line(s);
        r.corr = dot_product(n);
        r.final_flag = is_final && (n == 1);
        expected_corr_q.push_back(r);
        if (is_final) begin
            for (int unsigned t = 1; t < n; t++) begin
                shift_line('0);
                r.corr = dot_product(n);
                r.final_flag = (t == n - 1);
                expected_corr_q.push_back(r);
            end
            clear_line();
        end
    endfunction

    function automatic void check_result();
        corr_result_t exp_r;
        if (expected_corr_q.size() == 0) begin
            if (err_cnt < 10)
                $display("xcorr_checker: %0t unexpected result corr=%0d last_out=%0b",
                         $realtime, corr_value, last_out);
            err_cnt++;
            return;
        end
        exp_r = expected_corr_q.pop_front();
        if (corr_value !== exp_r.corr || last_out !== exp_r.final_flag) begin
            if (err_cnt < 10)
                $display("xcorr_checker: %0t mismatch corr exp=%0d got=%0d last_out exp=%0b got=%0b",
                         $realtime, exp_r.corr, corr_value, exp_r.final_flag, last_out);
            err_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tap_count_reg = TAP_COUNT_RESET;
            clear_line();
            expected_corr_q.delete();
            err_cnt = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT)
                tap_count_reg = pwdata[TCNT_W-1:0];
            if (result_valid && !result_stall)
                check_result();
            if (item_valid && !item_stall) begin
                if (op == OP_LOAD) begin
                    if (tap_index < MAX_TAPS)
                        tap_store[tap_index] = sample;
                end else begin
                    predict_correlation(sample, last);
                end
            end
            mismatch_count <= err_cnt;
            pending_count <= expected_corr_q.size();
        end
    end

endmodule

>>> sim/tb_full_cross_correlation_top.sv
`timescale 1ns / 1ps
// Testbench top for full_cross_correlation_top: clock, reset, register writes,
// item stimulus and result stalls. Depends on xcorr_pkg and xcorr_checker.
module tb_full_cross_correlation_top;
    import xcorr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 14;
    localparam int NUM_PHASES    = 9;
    localparam int TAP_PLAN [NUM_PHASES] = '{32, 1, 17, 0, 2, 63, 5, 33, 3};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic                       op = OP_LOAD;
    logic [TIDX_W-1:0]          tap_index = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       last = 1'b0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [CORR_W-1:0]   corr_value;
    logic                       last_out;

    int                         mismatch_count;
    int                         pending_count;
    int                         cycle_count = 0;
    int unsigned                send_idle_pct = 0;
    int unsigned                recv_idle_pct = 0;
    int unsigned                active_taps = MAX_TAPS_DEF;
    logic [MAX_TAPS_DEF-1:0]    tap_loaded = '0;

    full_cross_correlation_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .tap_index    (tap_index),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .corr_value   (corr_value),
        .last_out     (last_out)
    );

    xcorr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .op             (op),
        .tap_index      (tap_index),
        .sample         (sample),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .corr_value     (corr_value),
        .last_out       (last_out),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_full_cross_correlation_top: done, errors");
            $finish;
        end
    end

    task automatic set_tap_count(input logic [TCNT_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TAP_COUNT, 2'b00};
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (value == 0)
            active_taps = 1;
        else if (value > MAX_TAPS_DEF)
            active_taps = MAX_TAPS_DEF;
        else
            active_taps = value;
    endtask

    task automatic send_item(input logic op_v, input logic [TIDX_W-1:0] idx_v,
                             input logic signed [SAMPLE_W-1:0] smp_v, input logic last_v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op <= op_v;
        tap_index <= idx_v;
        sample <= smp_v;
        last <= last_v;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (op_v == OP_LOAD)
            tap_loaded[idx_v] = 1'b1;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(3) == 0)
            case ($urandom_range(3))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_random_item();
        if ($urandom_range(99) < 15)
            send_item(OP_LOAD, TIDX_W'($urandom), pick_sample(), 1'($urandom_range(1)));
        else
            send_item(OP_SIGNAL, TIDX_W'($urandom), pick_sample(),
                      ($urandom_range(99) < 10));
    endtask

    task automatic load_missing_taps();
        for (int i = 0; i < active_taps; i++)
            if (!tap_loaded[i])
                send_item(OP_LOAD, TIDX_W'(i), pick_sample(), 1'b0);
    endtask

    // idle point: no transfer in flight and every expected value delivered
    task automatic wait_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 28;
        recv_idle_pct = 55;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_tap_count(3);
        send_item(OP_LOAD, 0, -16'sd32768, 1'b1);
        send_item(OP_LOAD, 1, -16'sd32768, 1'b0);
        send_item(OP_LOAD, 2, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 31, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd32768, 1'b1);
        send_item(OP_LOAD, 0, 16'sd32767, 1'b0);
        send_item(OP_LOAD, 1, 16'sd32767, 1'b0);
        send_item(OP_LOAD, 2, 16'sd32767, 1'b0);
        send_item(OP_LOAD, 31, -16'sd1, 1'b1);
        send_item(OP_SIGNAL, 0, 16'sd32767, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd32768, 1'b0);
        send_item(OP_SIGNAL, 0, 16'sd0, 1'b0);
        send_item(OP_SIGNAL, 0, 16'sd1, 1'b0);
        send_item(OP_SIGNAL, 0, -16'sd1, 1'b1);
        send_item(OP_SIGNAL, 21, 16'sd12345, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 28;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_quiet();
            set_tap_count(TCNT_W'(TAP_PLAN[phase]));
            load_missing_taps();
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_item();
            send_item(OP_SIGNAL, TIDX_W'($urandom), pick_sample(), 1'b1);
        end
        wait_quiet();

        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_full_cross_correlation_top: done, clean");
        else
            $display("tb_full_cross_correlation_top: done, errors");
        $finish;
    end

endmodule
